// ----- src/insert_erase_shift_array_assert.svh -----
// Assertion macros for the insert/erase shift array checker.
// No dependencies; the including module must have clk_i and rst_ni.
`ifndef INSERT_ERASE_SHIFT_ARRAY_ASSERT_SVH
`define INSERT_ERASE_SHIFT_ARRAY_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define IES_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that only applies while a response is presented.
`define IES_ASSERT_RSP(name, prop, msg) \
  `IES_ASSERT(name, rsp_valid_i |-> (prop), msg)

`endif

// ----- src/ies_pkg.sv -----
// Shared types and constants for the insert/erase shift array.
// No dependencies.
package ies_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_e;

  // Broadcast to every cell; each cell compares its own position.
  typedef struct packed {
    cell_op_e                 op;
    logic [IDX_W-1:0]         index;
    logic [CNT_W-1:0]         fill;
    logic signed [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- src/ies_req_if.sv -----
// Request and response channel interfaces for the insert/erase shift array.
// Depends on ies_pkg.
interface ies_req_if;
  import ies_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [IDX_W-1:0]         index;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, kind, index, value, input ready);
  modport sink   (input valid, kind, index, value, output ready);
endinterface

interface ies_rsp_if;
  import ies_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] data;
  logic [CNT_W-1:0]         count;
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] back_word;

  modport source (output valid, status, data, count, front_word, back_word, input ready);
  modport sink   (input valid, status, data, count, front_word, back_word, output ready);
endinterface

// ----- src/ies_cell.sv -----
// One storage cell of the shift array: holds a word, loads the new value,
// or takes the word of its left or right neighbor. Depends on ies_pkg.
module ies_cell (
  input  logic                              clk_i,
  input  logic [ies_pkg::IDX_W-1:0]         pos_i,
  input  ies_pkg::cell_cmd_t                cmd_i,
  input  logic signed [ies_pkg::WORD_W-1:0] left_word_i,
  input  logic signed [ies_pkg::WORD_W-1:0] right_word_i,
  output logic signed [ies_pkg::WORD_W-1:0] word_o
);
  import ies_pkg::*;

  logic signed [WORD_W-1:0] word_d, word_q;
  logic [CNT_W-1:0]         pos_ext;

  assign pos_ext = CNT_W'(pos_i);

  always_comb begin
    word_d = word_q;
    unique case (cmd_i.op)
      CELL_APPEND: begin
        if (pos_ext == cmd_i.fill) word_d = cmd_i.value;
      end
      CELL_INSERT: begin
        // open a gap at the index, later words move up
        if (pos_i == cmd_i.index)     word_d = cmd_i.value;
        else if (pos_i > cmd_i.index) word_d = left_word_i;
      end
      CELL_ERASE: begin
        if (pos_i >= cmd_i.index) word_d = right_word_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- src/insert_erase_shift_array.sv -----
// Top level of the insert/erase shift array: command decode, row of cells,
// and response register. Depends on ies_pkg, ies_req_if/ies_rsp_if, ies_cell.
//
// Usage:
//   req_i carries one operation per request: kind (push, pop, insert, erase,
//   read), index and value. rsp_o returns one response per request with
//   status, data, the count after the operation and the front and back words.
//   A request is taken on a clock edge where valid and ready are both high.
//   The response is registered and appears in the cycle after the request
//   is taken. Throughput: one request per cycle while rsp_o.ready is high;
//   every cell of the row shifts in parallel with its neighbors, so insert
//   and erase finish in the same cycle as push, pop and read.
//   The response register is the only buffer: while a response waits,
//   req_i.ready follows rsp_o.ready, so a stalled receiver holds off new
//   requests without losing the pending response.
//   Reset (rst_ni low) empties the array and drops any pending response;
//   the stored words are not cleared and are never read before written.
module insert_erase_shift_array (
  input  logic clk_i,
  input  logic rst_ni,
  ies_req_if.sink   req_i,
  ies_rsp_if.source rsp_o
);
  import ies_pkg::*;

  logic signed [WORD_W-1:0] cell_word [DEPTH];
  cell_cmd_t                cmd;
  cell_op_e                 op;

  logic [CNT_W-1:0]         fill_d, fill_q;
  logic                     rsp_valid_q;
  logic [STAT_W-1:0]        status_d, status_q;
  logic signed [WORD_W-1:0] data_d, data_q;
  logic signed [WORD_W-1:0] front_d, front_q;
  logic signed [WORD_W-1:0] back_d, back_q;
  logic [CNT_W-1:0]         count_q;

  logic                     accept;
  logic                     in_range, is_full, is_empty;
  logic [CNT_W-1:0]         last_pos, prev_pos;
  logic signed [WORD_W-1:0] w_idx, w_last, w_prev;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign in_range = CNT_W'(req_i.index) < fill_q;
  assign is_full  = fill_q == CNT_W'(DEPTH);
  assign is_empty = fill_q == '0;
  assign last_pos = fill_q - CNT_W'(1);
  assign prev_pos = fill_q - CNT_W'(2);

  // Select words out of the row with one-hot matches per cell.
  always_comb begin
    w_idx  = '0;
    w_last = '0;
    w_prev = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) == req_i.index) w_idx  = w_idx  | cell_word[i];
      if (CNT_W'(i) == last_pos)    w_last = w_last | cell_word[i];
      if (CNT_W'(i) == prev_pos)    w_prev = w_prev | cell_word[i];
    end
  end

  always_comb begin
    op       = CELL_HOLD;
    status_d = ST_RANGE;
    data_d   = NEG_ONE;
    fill_d   = fill_q;
    front_d  = cell_word[0];
    back_d   = w_last;
    case (req_i.kind)
      KIND_PUSH: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          data_d   = '0;
          op       = CELL_APPEND;
          fill_d   = fill_q + CNT_W'(1);
          back_d   = req_i.value;
          if (is_empty) front_d = req_i.value;
        end
      end
      KIND_POP: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_OK;
          data_d   = w_last;
          fill_d   = last_pos;
          back_d   = w_prev;
        end
      end
      KIND_INSERT: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          data_d   = '0;
          op       = CELL_INSERT;
          fill_d   = fill_q + CNT_W'(1);
          if (req_i.index == '0) front_d = req_i.value;
        end
      end
      KIND_ERASE: begin
        if (in_range) begin
          status_d = ST_OK;
          data_d   = '0;
          op       = CELL_ERASE;
          fill_d   = last_pos;
          // the last word slides down unless it is the one dropped
          back_d   = (CNT_W'(req_i.index) == last_pos) ? w_prev : w_last;
          if (req_i.index == '0) front_d = cell_word[1];
        end
      end
      KIND_READ: begin
        if (in_range) begin
          status_d = ST_OK;
          data_d   = w_idx;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
    if (fill_d == '0) begin
      front_d = NEG_ONE;
      back_d  = NEG_ONE;
    end
  end

  assign cmd.op    = accept ? op : CELL_HOLD;
  assign cmd.index = req_i.index;
  assign cmd.fill  = fill_q;
  assign cmd.value = req_i.value;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_word, right_word;
    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_word = cell_word[g];
    end else begin : g_mid_r
      assign right_word = cell_word[g+1];
    end
    ies_cell u_cell (
      .clk_i        (clk_i),
      .pos_i        (IDX_W'(g)),
      .cmd_i        (cmd),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= data_d;
      count_q  <= fill_d;
      front_q  <= front_d;
      back_q   <= back_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.data       = data_q;
  assign rsp_o.count      = count_q;
  assign rsp_o.front_word = front_q;
  assign rsp_o.back_word  = back_q;

endmodule

// ----- src/ies_checker.sv -----
// Port-level checks for the insert/erase shift array, bound to the top level.
// Depends on ies_pkg and insert_erase_shift_array_assert.svh.
`include "insert_erase_shift_array_assert.svh"

module ies_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [ies_pkg::STAT_W-1:0]        rsp_status_i,
  input logic signed [ies_pkg::WORD_W-1:0] rsp_data_i,
  input logic [ies_pkg::CNT_W-1:0]         rsp_count_i,
  input logic signed [ies_pkg::WORD_W-1:0] rsp_front_i,
  input logic signed [ies_pkg::WORD_W-1:0] rsp_back_i
);
  import ies_pkg::*;

  `IES_ASSERT(a_req_gives_rsp, req_valid_i && req_ready_i |=> rsp_valid_i, "request without response")
  `IES_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i) && $stable(rsp_count_i), "stalled response changed")
  `IES_ASSERT_RSP(a_count_max, rsp_count_i <= CNT_W'(DEPTH), "count above depth")
  `IES_ASSERT_RSP(a_empty_ends, rsp_count_i != '0 || (rsp_front_i == NEG_ONE && rsp_back_i == NEG_ONE), "empty array shows a word")
  `IES_ASSERT_RSP(a_error_data, rsp_status_i == ST_OK || rsp_data_i == NEG_ONE, "error without all-ones data")

endmodule

bind insert_erase_shift_array ies_checker u_ies_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_data_i   (rsp_o.data),
  .rsp_count_i  (rsp_o.count),
  .rsp_front_i  (rsp_o.front_word),
  .rsp_back_i   (rsp_o.back_word)
);

// ----- tb/ies_reply_checker.sv -----
`timescale 1ns / 100ps
// Reply checker for the insert/erase shift array testbench: watches both channels,
// keeps a shadow copy of the array, predicts each reply and compares it field by field.
// Depends on ies_pkg and the ies_req_if/ies_rsp_if interfaces.
module ies_reply_checker
  import ies_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ies_req_if          req_mon,
  ies_rsp_if          rsp_mon,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned ok_count_o,
  output int unsigned empty_count_o,
  output int unsigned range_count_o,
  output int unsigned full_count_o
);

  typedef struct packed {
    status_e                  status;
    logic signed [WORD_W-1:0] data;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
  } reply_t;

  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  logic [CNT_W-1:0]         shadow_fill;
  reply_t                   expected_q [$];
  int unsigned              reply_index;

  // Apply one request to the shadow array and return the reply it should give.
  function automatic reply_t apply_op(input logic [KIND_W-1:0] kind,
                                      input logic [IDX_W-1:0] idx,
                                      input logic signed [WORD_W-1:0] val);
    reply_t                   r;
    status_e                  st;
    logic signed [WORD_W-1:0] word;
    int                       pos;
    st   = ST_OK;
    word = '0;
    case (kind)
      KIND_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          st   = ST_FULL;
          word = NEG_ONE;
        end else begin
          shadow_words[shadow_fill] = val;
          shadow_fill++;
        end
      end
      KIND_POP: begin
        if (shadow_fill == 0) begin
          st   = ST_EMPTY;
          word = NEG_ONE;
        end else begin
          shadow_fill--;
          word = shadow_words[shadow_fill];
        end
      end
      KIND_INSERT: begin
        // range check wins over full
        if ({1'b0, idx} >= shadow_fill) begin
          st   = ST_RANGE;
          word = NEG_ONE;
        end else if (shadow_fill >= DEPTH) begin
          st   = ST_FULL;
          word = NEG_ONE;
        end else begin
          for (pos = shadow_fill; pos > idx; pos--) shadow_words[pos] = shadow_words[pos-1];
          shadow_words[idx] = val;
          shadow_fill++;
        end
      end
      KIND_ERASE: begin
        if ({1'b0, idx} >= shadow_fill) begin
          st   = ST_RANGE;
          word = NEG_ONE;
        end else begin
          for (pos = idx; pos + 1 < shadow_fill; pos++) shadow_words[pos] = shadow_words[pos+1];
          shadow_fill--;
        end
      end
      KIND_READ: begin
        if ({1'b0, idx} >= shadow_fill) begin
          st   = ST_RANGE;
          word = NEG_ONE;
        end else begin
          word = shadow_words[idx];
        end
      end
      default: begin
        st   = ST_RANGE;
        word = NEG_ONE;
      end
    endcase
    r.status = st;
    r.data   = word;
    r.count  = shadow_fill;
    if (shadow_fill == 0) begin
      r.front_word = NEG_ONE;
      r.back_word  = NEG_ONE;
    end else begin
      r.front_word = shadow_words[0];
      r.back_word  = shadow_words[shadow_fill-1];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      shadow_fill = '0;
      reply_index = 0;
      expected_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      ok_count_o       <= 0;
      empty_count_o    <= 0;
      range_count_o    <= 0;
      full_count_o     <= 0;
    end else begin
      // The reply taken at this edge belongs to an earlier request: check it first.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status     = status_e'(rsp_mon.status);
        got.data       = rsp_mon.data;
        got.count      = rsp_mon.count;
        got.front_word = rsp_mon.front_word;
        got.back_word  = rsp_mon.back_word;
        case (got.status)
          ST_OK:    ok_count_o    <= ok_count_o + 1;
          ST_EMPTY: empty_count_o <= empty_count_o + 1;
          ST_RANGE: range_count_o <= range_count_o + 1;
          ST_FULL:  full_count_o  <= full_count_o + 1;
          default: ;
        endcase
        if (expected_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("Reply %0d arrived with no request waiting: status %0d data %0d count %0d",
                     reply_index, got.status, got.data, got.count);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.count !== want.count || got.front_word !== want.front_word ||
              got.back_word !== want.back_word) begin
            if (mismatch_count_o < 10) begin
              $display("Reply %0d mismatch (expected / actual):", reply_index);
              $display("  status %0d / %0d, data %0d / %0d, count %0d / %0d",
                       want.status, got.status, want.data, got.data, want.count, got.count);
              $display("  front %0d / %0d, back %0d / %0d",
                       want.front_word, got.front_word, want.back_word, got.back_word);
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
        reply_index++;
      end
      if (req_mon.valid && req_mon.ready)
        expected_q = {expected_q, apply_op(req_mon.kind, req_mon.index, req_mon.value)};
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/tb_insert_erase_shift_array.sv -----
`timescale 1ns / 100ps
// Testbench top for the insert/erase shift array: clock, reset, request and reply
// traffic with random idling and stalls, and the final verdict.
// Depends on ies_pkg, ies_req_if/ies_rsp_if, ies_reply_checker and the block itself.
module tb_insert_erase_shift_array;
  import ies_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RANDOM_REQUESTS = 550;
  localparam int unsigned RSP_HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES   = 8;

  localparam logic [KIND_W-1:0]        KIND_FIRST_SPARE = 3'd5;
  localparam logic [KIND_W-1:0]        KIND_LAST_SPARE  = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MAX         = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN         = 32'sh8000_0000;
  localparam logic [IDX_W-1:0]         IDX_LAST         = IDX_W'(DEPTH - 1);

  typedef enum int {
    SHAPE_FILL,
    SHAPE_DRAIN,
    SHAPE_MIXED,
    SHAPE_CHURN
  } shape_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatches, pending;
  int unsigned ok_seen, empty_seen, range_seen, full_seen;
  int unsigned requests_sent, directed_sent, cycle_count;
  int unsigned hold_requests;
  bit          req_burst, rsp_burst;

  ies_req_if req_if ();
  ies_rsp_if rsp_if ();

  insert_erase_shift_array dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ies_reply_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .ok_count_o       (ok_seen),
    .empty_count_o    (empty_seen),
    .range_count_o    (range_seen),
    .full_count_o     (full_seen)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly random words, with the extremes mixed in.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return NEG_ONE;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request after a random gap; keep valid high across back-to-back requests.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic signed [WORD_W-1:0] val);
    int unsigned gap;
    bit          took;
    if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
    gap = req_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.index <= idx;
    req_if.value <= val;
    do begin
      @(negedge clk_i);
      took = req_if.ready;
      @(posedge clk_i);
    end while (!took);
    requests_sent++;
  endtask

  // Drop valid and hold until every outstanding reply has been checked.
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Reply side: random ready gaps, idle-free stretches, and a long hold on request.
  initial begin
    int unsigned gap;
    int unsigned holds_done;
    bit          took;
    holds_done = 0;
    rsp_burst  = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < hold_requests) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      gap = rsp_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = rsp_if.valid;
        @(posedge clk_i);
      end while (!took);
    end
  end

  initial begin
    shape_e              shape;
    int unsigned         round, len;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    idx;
    req_if.valid  <= 1'b0;
    req_if.kind   <= KIND_PUSH;
    req_if.index  <= '0;
    req_if.value  <= '0;
    requests_sent = 0;
    hold_requests = 0;
    req_burst     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-array errors, extremes, front/back edits, spare kinds.
    send_request(KIND_POP, '0, '0);
    send_request(KIND_READ, '0, '0);
    send_request(KIND_INSERT, '0, WORD_MAX);
    send_request(KIND_ERASE, IDX_LAST, '0);
    send_request(KIND_PUSH, IDX_LAST, WORD_MAX);
    send_request(KIND_PUSH, '0, WORD_MIN);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, IDX_W'(2), NEG_ONE);
    send_request(KIND_READ, IDX_W'(3), WORD_MAX);
    send_request(KIND_READ, IDX_W'(4), '0);
    send_request(KIND_ERASE, '0, WORD_MIN);
    send_request(KIND_ERASE, IDX_W'(2), '0);
    for (int k = KIND_FIRST_SPARE; k <= KIND_LAST_SPARE; k++)
      send_request(KIND_W'(k), IDX_LAST, WORD_MIN);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_POP, IDX_LAST, WORD_MAX);
    send_request(KIND_PUSH, '0, 1);
    directed_sent = requests_sent;
    wait_for_drain();

    // Random rounds: fill and drain runs reach full and empty, mixed rounds churn the middle.
    round = 0;
    while (requests_sent < directed_sent + RANDOM_REQUESTS) begin
      shape = (round == 0) ? SHAPE_FILL : shape_e'($urandom_range(SHAPE_FILL, SHAPE_CHURN));
      len   = (shape == SHAPE_MIXED) ? 30 : $urandom_range(20, 24);
      if (round == 2 || round == 11) begin
        // hold the reply side while requests keep coming back to back
        hold_requests++;
        req_burst = 1'b1;
      end
      if (round == 6 || round == 15) wait_for_drain();
      repeat (len) begin
        case (shape)
          SHAPE_FILL:  kind = ($urandom_range(0, 9) < 8) ? KIND_PUSH : KIND_INSERT;
          SHAPE_DRAIN: kind = ($urandom_range(0, 9) < 6) ? KIND_POP : KIND_ERASE;
          SHAPE_MIXED: begin
            if ($urandom_range(0, 19) == 0)
              kind = KIND_W'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE));
            else
              kind = KIND_W'($urandom_range(KIND_PUSH, KIND_READ));
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       kind = KIND_PUSH;
              1:       kind = KIND_INSERT;
              2:       kind = KIND_ERASE;
              default: kind = KIND_READ;
            endcase
          end
        endcase
        // favor low positions so more inserts, erases and reads land inside the array
        idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, DEPTH - 1))
                                   : IDX_W'($urandom_range(0, 5));
        send_request(kind, idx, pick_word());
      end
      round++;
    end

    req_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d directed) over %0d random rounds in %0d cycles",
             requests_sent, directed_sent, round, cycle_count);
    $display("Replies by status: ok %0d, empty %0d, out of range %0d, full %0d",
             ok_seen, empty_seen, range_seen, full_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d replies missing", mismatches, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/ies_pkg.sv
src/ies_req_if.sv
src/ies_cell.sv
src/insert_erase_shift_array.sv
src/ies_checker.sv
tb/ies_reply_checker.sv
tb/tb_insert_erase_shift_array.sv
